/* src/sso_pkg.sv */
// Shared types and constants of the SR/CSI slot offset allocator.
package sso_pkg;

    localparam int SR_DEPTH   = 1024;
    localparam int SR_AW      = $clog2(SR_DEPTH);
    localparam int SR_CW      = 11;
    localparam int CSI_DEPTH  = 512;
    localparam int CSI_AW     = $clog2(CSI_DEPTH);
    localparam int CSI_CW     = 10;
    localparam int MIN_RS_REPORT_GAP = 4;
    localparam int MOD_STEPS  = 11;
    localparam int SR_ENTRY_W = 16;

    typedef enum logic [1:0] {
        CMD_BUILD   = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_SR_PERIOD     = 3'd0,
        CFG_CSI_PERIOD    = 3'd1,
        CFG_CSI_RS_PERIOD = 3'd2,
        CFG_CSI_RS_OFFSET = 3'd3,
        CFG_SR_RES_PER    = 3'd4,
        CFG_HARQ_F1_COUNT = 3'd5,
        CFG_TDD_LEN       = 3'd6,
        CFG_UL_MASK       = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD_SR,
        ST_BUILD_CSI,
        ST_RELEASE,
        ST_ALLOC_RD,
        ST_SR_MOD,
        ST_SCAN_RD,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] rel_sr_res_id;
        logic [9:0] rel_sr_offset;
        logic       rel_has_csi;
        logic [8:0] rel_csi_offset;
    } in_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  sr_res_id;
        logic [9:0]  sr_offset;
        logic        csi_valid;
        logic [8:0]  csi_offset;
        logic [10:0] sr_free_count;
        logic [9:0]  csi_free_count;
    } out_t;

    typedef struct packed {
        logic       start;
        logic [9:0] off;
    } wgt_req_t;

    typedef struct packed {
        logic        done;
        logic [10:0] weight;
        logic [9:0]  off_mod;
    } wgt_rsp_t;

endpackage

/* src/sso_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module sso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/sso_weight.sv */
// Iterative CSI offset weight unit: two bit-serial remainder lanes.
module sso_weight
    import sso_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wgt_req_t   req,
    input  logic [9:0] rs_offset,
    input  logic [9:0] rs_period,
    input  logic [9:0] low,
    input  logic [9:0] sr_mod,
    output wgt_rsp_t   rsp
);

    logic [10:0] a_reg, a_next;
    logic [10:0] b_reg, b_next;
    logic [9:0]  rema_reg, rema_next;
    logic [9:0]  remb_reg, remb_next;
    logic        neg_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [11:0] v;
    logic [11:0] mag;
    logic [10:0] ta, tb;
    logic [9:0]  ra;

    always_comb
    begin
        v   = {2'b00, req.off} - {2'b00, rs_offset} - 12'(MIN_RS_REPORT_GAP);
        mag = v[11] ? (12'd0 - v) : v;
        ta  = {rema_reg, a_reg[10]};
        tb  = {remb_reg, b_reg[10]};
        a_next = {a_reg[9:0], 1'b0};
        b_next = {b_reg[9:0], 1'b0};
        rema_next = (ta >= {1'b0, rs_period}) ? 10'(ta - {1'b0, rs_period}) : ta[9:0];
        remb_next = (tb >= {1'b0, low}) ? 10'(tb - {1'b0, low}) : tb[9:0];
        ra = (neg_reg && rema_reg != 10'd0) ? (rs_period - rema_reg) : rema_reg;
        rsp.done    = done_reg;
        rsp.weight  = {1'b0, ra} + ((sr_mod == remb_reg) ? {1'b0, rs_period} : 11'd0);
        rsp.off_mod = remb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            rema_reg <= '0;
            remb_reg <= '0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg    <= mag[10:0];
                b_reg    <= {1'b0, req.off};
                rema_reg <= '0;
                remb_reg <= '0;
                neg_reg  <= v[11];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                a_reg    <= a_next;
                b_reg    <= b_next;
                rema_reg <= rema_next;
                remb_reg <= remb_next;
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* src/sr_csi_slot_offset_allocator.sv */
// Top level of the SR/CSI slot offset allocator: control, registers and list memories.
// Commands run one at a time. Build walks every offset of the SR period, writing
// sr_res_per_offset entries per uplink offset, then every offset of the CSI report
// period, one entry per uplink offset, at most one list write a cycle. Allocate
// reads the SR list, reduces the SR offset, runs each CSI list entry through the
// 11-step remainder unit for its weight and moves the later entries up when the
// taken entry is removed; the CSI list memory has a single read port. A result
// waits in an output register while the next command is taken.
module sr_csi_slot_offset_allocator
    import sso_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    logic [9:0]  sr_cycle_reg, csi_rs_period_reg, csi_rs_offset_reg;
    logic [8:0]  csi_rpt_cycle_reg;
    logic [3:0]  sr_res_per_reg;
    logic [4:0]  harq_f1_reg;
    logic [6:0]  tdd_len_reg;
    logic [63:0] ul_mask_reg;

    state_t      state_reg, state_next;
    in_t         rel_reg;
    logic [10:0] sr_count_reg;
    logic [9:0]  csi_count_reg;
    logic [9:0]  off_reg;
    logic [6:0]  slot_reg;
    logic [3:0]  n_reg;
    logic [9:0]  idx_reg;
    logic [9:0]  best_reg;
    logic [10:0] bw_reg;
    logic [8:0]  cur_off_reg;
    logic [9:0]  sr_mod_reg;
    logic        ok_reg, cvalid_reg;
    logic [5:0]  rid_reg;
    logic [9:0]  roff_reg;
    logic [8:0]  coff_reg;
    logic        out_valid_reg;
    out_t        out_data_reg;

    logic        in_fire, out_free;
    logic        uplink, sr_full, csi_full;
    logic        sr_end, csi_end, sr_push_b;
    logic [6:0]  slot_inc;
    logic [6:0]  id_sum;
    logic [9:0]  rs_period_eff, sp_eff, low;
    logic        better;
    logic [9:0]  best_sel;
    logic [9:0]  idx_inc;

    logic                  sr_we;
    logic [SR_AW-1:0]      sr_waddr, sr_raddr;
    logic [SR_ENTRY_W-1:0] sr_wdata, sr_rdata;
    logic                  csi_we;
    logic [CSI_AW-1:0]     csi_waddr, csi_raddr;
    logic [8:0]            csi_wdata, csi_rdata;
    wgt_req_t              wreq;
    wgt_rsp_t              wrsp;

    sso_ram #(.WIDTH(SR_ENTRY_W), .DEPTH(SR_DEPTH)) u_sr_ram (
        .clk   (clk),
        .we    (sr_we),
        .waddr (sr_waddr),
        .wdata (sr_wdata),
        .raddr (sr_raddr),
        .rdata (sr_rdata)
    );

    sso_ram #(.WIDTH(9), .DEPTH(CSI_DEPTH)) u_csi_ram (
        .clk   (clk),
        .we    (csi_we),
        .waddr (csi_waddr),
        .wdata (csi_wdata),
        .raddr (csi_raddr),
        .rdata (csi_rdata)
    );

    sso_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (wreq),
        .rs_offset (csi_rs_offset_reg),
        .rs_period (rs_period_eff),
        .low       (low),
        .sr_mod    (sr_mod_reg),
        .rsp       (wrsp)
    );

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        in_fire   = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        out_valid = out_valid_reg;
        out_data  = out_data_reg;

        rs_period_eff = (csi_rs_period_reg == 10'd0) ? 10'd1 : csi_rs_period_reg;
        sp_eff        = (sr_cycle_reg == 10'd0) ? 10'd1 : sr_cycle_reg;
        low           = (rs_period_eff < sp_eff) ? rs_period_eff : sp_eff;

        uplink   = (tdd_len_reg == 7'd0) || (!slot_reg[6] && ul_mask_reg[slot_reg[5:0]]);
        slot_inc = ((slot_reg + 7'd1) == tdd_len_reg) ? 7'd0 : (slot_reg + 7'd1);
        sr_full  = sr_count_reg >= 11'(SR_DEPTH);
        csi_full = csi_count_reg >= 10'(CSI_DEPTH);
        sr_end   = off_reg >= sr_cycle_reg;
        csi_end  = off_reg >= {1'b0, csi_rpt_cycle_reg};
        sr_push_b = !sr_end && uplink && (n_reg < sr_res_per_reg);
        id_sum   = {2'b00, harq_f1_reg} + {3'b000, sr_res_per_reg} - 7'd1 - {3'b000, n_reg};
        better   = (idx_reg == 10'd0) || (wrsp.weight < bw_reg);
        best_sel = better ? idx_reg : best_reg;
        idx_inc  = idx_reg + 10'd1;

        sr_we    = 1'b0;
        sr_waddr = sr_count_reg[SR_AW-1:0];
        sr_wdata = {rel_reg.rel_sr_res_id, rel_reg.rel_sr_offset};
        sr_raddr = SR_AW'(sr_count_reg - 11'd1);
        csi_we    = 1'b0;
        csi_waddr = csi_count_reg[CSI_AW-1:0];
        csi_wdata = rel_reg.rel_csi_offset;
        csi_raddr = idx_reg[CSI_AW-1:0];
        wreq.start = 1'b0;
        wreq.off   = sr_rdata[9:0];
        state_next = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.command)
                        CMD_BUILD:   state_next = ST_BUILD_SR;
                        CMD_ALLOC:   state_next = (sr_count_reg != 11'd0) ? ST_ALLOC_RD
                                                                          : ST_RESULT;
                        CMD_RELEASE: state_next = ST_RELEASE;
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_BUILD_SR:
            begin
                sr_we    = sr_push_b && !sr_full;
                sr_wdata = {id_sum[5:0], off_reg};
                if (sr_end)
                begin
                    state_next = ST_BUILD_CSI;
                end
            end
            ST_BUILD_CSI:
            begin
                csi_we    = !csi_end && uplink && !csi_full;
                csi_wdata = off_reg[8:0];
                if (csi_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RELEASE:
            begin
                sr_we      = !sr_full;
                csi_we     = rel_reg.rel_has_csi && !csi_full;
                state_next = ST_RESULT;
            end
            ST_ALLOC_RD:
            begin
                if (csi_rpt_cycle_reg == 9'd0 || csi_count_reg == 10'd0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    wreq.start = 1'b1;
                    state_next = ST_SR_MOD;
                end
            end
            ST_SR_MOD:
            begin
                if (wrsp.done)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_START;
            end
            ST_SCAN_START:
            begin
                wreq.start = 1'b1;
                wreq.off   = {1'b0, csi_rdata};
                state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (wrsp.done)
                begin
                    state_next = (idx_inc == csi_count_reg) ? ST_CMP_RD : ST_SCAN_RD;
                end
            end
            ST_CMP_RD:
            begin
                csi_raddr  = idx_inc[CSI_AW-1:0];
                state_next = (idx_inc >= csi_count_reg) ? ST_RESULT : ST_CMP_WR;
            end
            ST_CMP_WR:
            begin
                csi_we     = 1'b1;
                csi_waddr  = idx_reg[CSI_AW-1:0];
                csi_wdata  = csi_rdata;
                state_next = ST_CMP_RD;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_cycle_reg      <= 10'd40;
            csi_rpt_cycle_reg <= 9'd0;
            csi_rs_period_reg <= 10'd20;
            csi_rs_offset_reg <= 10'd0;
            sr_res_per_reg    <= 4'd2;
            harq_f1_reg       <= 5'd6;
            tdd_len_reg       <= 7'd0;
            ul_mask_reg       <= '1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SR_PERIOD:     sr_cycle_reg      <= cfg_data[9:0];
                CFG_CSI_PERIOD:    csi_rpt_cycle_reg <= cfg_data[8:0];
                CFG_CSI_RS_PERIOD: csi_rs_period_reg <= cfg_data[9:0];
                CFG_CSI_RS_OFFSET: csi_rs_offset_reg <= cfg_data[9:0];
                CFG_SR_RES_PER:    sr_res_per_reg    <= cfg_data[3:0];
                CFG_HARQ_F1_COUNT: harq_f1_reg       <= cfg_data[4:0];
                CFG_TDD_LEN:       tdd_len_reg       <= cfg_data[6:0];
                CFG_UL_MASK:       ul_mask_reg       <= cfg_data;
                default:           ul_mask_reg       <= ul_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_count_reg  <= '0;
            csi_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && in_data.command == CMD_BUILD)
                    begin
                        sr_count_reg  <= '0;
                        csi_count_reg <= '0;
                    end
                    else if (in_fire && in_data.command == CMD_ALLOC && sr_count_reg != 11'd0)
                    begin
                        sr_count_reg <= sr_count_reg - 11'd1;
                    end
                end
                ST_BUILD_SR:
                begin
                    if (sr_push_b && !sr_full)
                    begin
                        sr_count_reg <= sr_count_reg + 11'd1;
                    end
                end
                ST_BUILD_CSI:
                begin
                    if (!csi_end && uplink && !csi_full)
                    begin
                        csi_count_reg <= csi_count_reg + 10'd1;
                    end
                end
                ST_RELEASE:
                begin
                    if (!sr_full)
                    begin
                        sr_count_reg <= sr_count_reg + 11'd1;
                    end
                    if (rel_reg.rel_has_csi && !csi_full)
                    begin
                        csi_count_reg <= csi_count_reg + 10'd1;
                    end
                end
                ST_ALLOC_RD:
                begin
                    if (csi_rpt_cycle_reg != 9'd0 && csi_count_reg == 10'd0)
                    begin
                        sr_count_reg <= sr_count_reg + 11'd1;
                    end
                end
                ST_CMP_RD:
                begin
                    if (idx_inc >= csi_count_reg)
                    begin
                        csi_count_reg <= csi_count_reg - 10'd1;
                    end
                end
                default:
                begin
                    csi_count_reg <= csi_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RESULT && out_free)
        begin
            out_data_reg.ok             <= ok_reg;
            out_data_reg.sr_res_id      <= rid_reg;
            out_data_reg.sr_offset      <= roff_reg;
            out_data_reg.csi_valid      <= cvalid_reg;
            out_data_reg.csi_offset     <= coff_reg;
            out_data_reg.sr_free_count  <= sr_count_reg;
            out_data_reg.csi_free_count <= csi_count_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rel_reg    <= in_data;
                    ok_reg     <= 1'b0;
                    rid_reg    <= '0;
                    roff_reg   <= '0;
                    cvalid_reg <= 1'b0;
                    coff_reg   <= '0;
                    off_reg    <= '0;
                    slot_reg   <= '0;
                    n_reg      <= '0;
                end
            end
            ST_BUILD_SR:
            begin
                if (sr_end)
                begin
                    off_reg  <= '0;
                    slot_reg <= '0;
                    n_reg    <= '0;
                end
                else if (!uplink || n_reg >= sr_res_per_reg)
                begin
                    off_reg  <= off_reg + 10'd1;
                    slot_reg <= slot_inc;
                    n_reg    <= '0;
                end
                else
                begin
                    n_reg <= n_reg + 4'd1;
                end
            end
            ST_BUILD_CSI:
            begin
                if (csi_end)
                begin
                    ok_reg <= 1'b1;
                end
                else
                begin
                    off_reg  <= off_reg + 10'd1;
                    slot_reg <= slot_inc;
                end
            end
            ST_RELEASE:
            begin
                ok_reg <= !sr_full && !(rel_reg.rel_has_csi && csi_full);
            end
            ST_ALLOC_RD:
            begin
                rid_reg  <= sr_rdata[15:10];
                roff_reg <= sr_rdata[9:0];
                if (csi_rpt_cycle_reg == 9'd0)
                begin
                    ok_reg <= 1'b1;
                end
            end
            ST_SR_MOD:
            begin
                if (wrsp.done)
                begin
                    sr_mod_reg <= wrsp.off_mod;
                    idx_reg    <= '0;
                end
            end
            ST_SCAN_START:
            begin
                cur_off_reg <= csi_rdata;
            end
            ST_SCAN_WAIT:
            begin
                if (wrsp.done)
                begin
                    if (better)
                    begin
                        bw_reg   <= wrsp.weight;
                        best_reg <= idx_reg;
                        coff_reg <= cur_off_reg;
                    end
                    idx_reg <= (idx_inc == csi_count_reg) ? best_sel : idx_inc;
                end
            end
            ST_CMP_RD:
            begin
                if (idx_inc >= csi_count_reg)
                begin
                    ok_reg     <= 1'b1;
                    cvalid_reg <= 1'b1;
                end
            end
            ST_CMP_WR:
            begin
                idx_reg <= idx_inc;
            end
            default:
            begin
                ok_reg <= ok_reg;
            end
        endcase

        if (state_reg == ST_ALLOC_RD && csi_rpt_cycle_reg != 9'd0 && csi_count_reg == 10'd0)
        begin
            rid_reg  <= '0;
            roff_reg <= '0;
        end
        if (state_reg == ST_CMP_RD && idx_inc < csi_count_reg)
        begin
            ok_reg <= 1'b0;
        end
    end

endmodule

/* tb/tb_sr_csi_slot_offset_allocator.sv */
// Self-checking testbench for the SR/CSI slot offset allocator, with an in-bench list predictor.
module tb_sr_csi_slot_offset_allocator
    import sso_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;

    sr_csi_slot_offset_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #4 clk = ~clk;

    int unsigned m_sr_cycle = 40, m_csi_rpt_cycle = 0, m_rs_period = 20, m_rs_offset = 0;
    int unsigned m_res_per = 2, m_harq = 6, m_tdd_len = 0;
    logic [63:0] m_ul_mask = '1;

    logic [5:0]  free_sr_ids [SR_DEPTH];
    logic [9:0]  free_sr_offs [SR_DEPTH];
    int unsigned free_sr_count = 0;
    logic [8:0]  free_csi_offs [CSI_DEPTH];
    int unsigned free_csi_count = 0;

    in_t  cmd_backlog [$];
    out_t grant_expected [$];
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   errors = 0;

    function automatic bit slot_is_uplink(int unsigned off);
        int unsigned slot;
        if (m_tdd_len == 0)
            return 1'b1;
        slot = off % m_tdd_len;
        if (slot >= 64)
            return 1'b0;
        return m_ul_mask[slot];
    endfunction

    function automatic bit push_sr(int unsigned id, int unsigned off);
        if (free_sr_count >= SR_DEPTH)
            return 1'b0;
        free_sr_ids[free_sr_count] = id[5:0];
        free_sr_offs[free_sr_count] = off[9:0];
        free_sr_count++;
        return 1'b1;
    endfunction

    function automatic bit push_csi(int unsigned off);
        if (free_csi_count >= CSI_DEPTH)
            return 1'b0;
        free_csi_offs[free_csi_count] = off[8:0];
        free_csi_count++;
        return 1'b1;
    endfunction

    function automatic int csi_slot_weight(int off, int sr_off);
        int p, v, r, sp, lo;
        p = (m_rs_period != 0) ? int'(m_rs_period) : 1;
        v = off - int'(m_rs_offset) - MIN_RS_REPORT_GAP;
        r = v % p;
        if (r < 0)
            r += p;
        sp = (m_sr_cycle != 0) ? int'(m_sr_cycle) : 1;
        lo = (p < sp) ? p : sp;
        if (sr_off % lo == off % lo)
            r += p;
        return r;
    endfunction

    function automatic out_t allocator_predict(in_t item);
        out_t res;
        int unsigned pid, poff, best, bw, w;
        bit dummy;
        res = '0;
        if (item.command == CMD_BUILD) begin
            free_sr_count = 0;
            free_csi_count = 0;
            for (int unsigned off = 0; off < m_sr_cycle; off++)
                if (slot_is_uplink(off))
                    for (int unsigned n = 0; n < m_res_per; n++)
                        dummy = push_sr(m_harq + m_res_per - 1 - n, off);
            for (int unsigned off = 0; off < m_csi_rpt_cycle; off++)
                if (slot_is_uplink(off))
                    dummy = push_csi(off);
            res.ok = 1'b1;
        end else if (item.command == CMD_ALLOC) begin
            if (free_sr_count != 0) begin
                pid = free_sr_ids[free_sr_count - 1];
                poff = free_sr_offs[free_sr_count - 1];
                free_sr_count--;
                if (m_csi_rpt_cycle == 0) begin
                    res.ok = 1'b1;
                    res.sr_res_id = pid[5:0];
                    res.sr_offset = poff[9:0];
                end else if (free_csi_count == 0) begin
                    dummy = push_sr(pid, poff);
                end else begin
                    best = 0;
                    bw = csi_slot_weight(free_csi_offs[0], poff);
                    for (int unsigned i = 1; i < free_csi_count; i++) begin
                        w = csi_slot_weight(free_csi_offs[i], poff);
                        if (w < bw) begin
                            bw = w;
                            best = i;
                        end
                    end
                    res.csi_offset = free_csi_offs[best];
                    for (int unsigned i = best; i + 1 < free_csi_count; i++)
                        free_csi_offs[i] = free_csi_offs[i + 1];
                    free_csi_count--;
                    res.ok = 1'b1;
                    res.sr_res_id = pid[5:0];
                    res.sr_offset = poff[9:0];
                    res.csi_valid = 1'b1;
                end
            end
        end else if (item.command == CMD_RELEASE) begin
            res.ok = 1'b1;
            if (!push_sr(item.rel_sr_res_id, item.rel_sr_offset))
                res.ok = 1'b0;
            if (item.rel_has_csi && !push_csi(item.rel_csi_offset))
                res.ok = 1'b0;
        end
        res.sr_free_count = free_sr_count[10:0];
        res.csi_free_count = free_csi_count[9:0];
        return res;
    endfunction

    function automatic void queue_cmd(in_t t);
        cmd_backlog = {cmd_backlog, t};
    endfunction

    // driver: predict on each accepted transfer, then present the next one
    always @(posedge clk) begin
        if (in_valid && !in_stall)
            grant_expected = {grant_expected, allocator_predict(in_data)};
        if (!in_valid || !in_stall) begin
            if (rst_n && cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
                in_data <= cmd_backlog.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk) begin
        out_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (grant_expected.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = grant_expected.pop_front();
                check_field("ok", e.ok, out_data.ok);
                check_field("sr_res_id", e.sr_res_id, out_data.sr_res_id);
                check_field("sr_offset", e.sr_offset, out_data.sr_offset);
                check_field("csi_valid", e.csi_valid, out_data.csi_valid);
                check_field("csi_offset", e.csi_offset, out_data.csi_offset);
                check_field("sr_free_count", e.sr_free_count, out_data.sr_free_count);
                check_field("csi_free_count", e.csi_free_count, out_data.csi_free_count);
            end
        end
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SR_PERIOD:     m_sr_cycle = 32'(val[9:0]);
            CFG_CSI_PERIOD:    m_csi_rpt_cycle = 32'(val[8:0]);
            CFG_CSI_RS_PERIOD: m_rs_period = 32'(val[9:0]);
            CFG_CSI_RS_OFFSET: m_rs_offset = 32'(val[9:0]);
            CFG_SR_RES_PER:    m_res_per = 32'(val[3:0]);
            CFG_HARQ_F1_COUNT: m_harq = 32'(val[4:0]);
            CFG_TDD_LEN:       m_tdd_len = 32'(val[6:0]);
            CFG_UL_MASK:       m_ul_mask = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(int sp, int cp, int rp, int ro, int rpo, int hq, int tl,
                             logic [63:0] mask);
        write_reg(CFG_SR_PERIOD, 64'(sp));
        write_reg(CFG_CSI_PERIOD, 64'(cp));
        write_reg(CFG_CSI_RS_PERIOD, 64'(rp));
        write_reg(CFG_CSI_RS_OFFSET, 64'(ro));
        write_reg(CFG_SR_RES_PER, 64'(rpo));
        write_reg(CFG_HARQ_F1_COUNT, 64'(hq));
        write_reg(CFG_TDD_LEN, 64'(tl));
        write_reg(CFG_UL_MASK, mask);
    endtask

    task automatic drain();
        while (cmd_backlog.size() > 0 || in_valid || grant_expected.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic in_t mk(logic [1:0] c, int id = 0, int off = 0, bit has = 0, int co = 0);
        in_t t;
        t.command = c;
        t.rel_sr_res_id = id[5:0];
        t.rel_sr_offset = off[9:0];
        t.rel_has_csi = has;
        t.rel_csi_offset = co[8:0];
        return t;
    endfunction

    function automatic in_t random_item();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return mk(CMD_ALLOC);
        if (r < 88)
            return mk(CMD_RELEASE, $urandom_range(63), $urandom_range(639),
                      1'($urandom_range(1)), $urandom_range(319));
        if (r < 96)
            return mk(CMD_BUILD, $urandom_range(63), $urandom_range(639),
                      1'($urandom_range(1)), $urandom_range(319));
        return mk(CMD_UNUSED, $urandom_range(63), $urandom_range(639),
                  1'($urandom_range(1)), $urandom_range(319));
    endfunction

    function automatic void set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 55; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 19; stall_pct = 19; end
        endcase
    endfunction

    initial begin
        int sp, cp;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset settings: empty lists, extreme release fields, unused code
        queue_cmd(mk(CMD_ALLOC));
        queue_cmd(mk(CMD_RELEASE, 63, 639, 1, 319));
        queue_cmd(mk(CMD_RELEASE, 0, 0, 0, 0));
        queue_cmd(mk(CMD_UNUSED, 63, 639, 1, 319));
        queue_cmd(mk(CMD_BUILD));
        queue_cmd(mk(CMD_ALLOC));
        queue_cmd(mk(CMD_ALLOC));
        drain();

        // TDD pattern with CSI: run the CSI list dry
        configure(12, 8, 5, 639, 8, 31, 10, 64'h0000_0000_0000_02AD);
        set_idling(3);
        queue_cmd(mk(CMD_BUILD));
        repeat (7) queue_cmd(mk(CMD_ALLOC));
        queue_cmd(mk(CMD_RELEASE, 5, 3, 1, 2));
        queue_cmd(mk(CMD_ALLOC));
        drain();

        // largest periods: SR list overflows on build and release, then fill CSI list
        configure(640, 320, 640, 0, 8, 0, 64, '1);
        set_idling(0);
        queue_cmd(mk(CMD_BUILD));
        queue_cmd(mk(CMD_RELEASE, 1, 1, 0, 0));
        repeat (3) queue_cmd(mk(CMD_ALLOC));
        repeat (200)
            queue_cmd(mk(CMD_RELEASE, $urandom_range(63), $urandom_range(639),
                         1'b1, $urandom_range(319)));
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            sp = ($urandom_range(9) == 0) ? 640 : $urandom_range(1, 80);
            cp = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 48);
            configure(sp, cp, (ph == 1) ? 5 : $urandom_range(5, 640),
                      (ph == 2) ? 639 : $urandom_range(639), $urandom_range(1, 8),
                      $urandom_range(31), ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 64),
                      {$urandom, $urandom});
            set_idling(ph);
            queue_cmd(mk(CMD_BUILD));
            repeat (40) queue_cmd(random_item());
            drain();
        end

        if (errors == 0)
            $display("sr_csi_slot_offset_allocator verification clean");
        else
            $display("sr_csi_slot_offset_allocator verification failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("sr_csi_slot_offset_allocator verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/sso_pkg.sv
src/sso_ram.sv
src/sso_weight.sv
src/sr_csi_slot_offset_allocator.sv
tb/tb_sr_csi_slot_offset_allocator.sv
